### rtl/siu_pkg.sv
`default_nettype none
package siu_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int VALUE_W     = 32;
    localparam int MATCH_W     = 6;
    localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the accepted element, clear scan state
        logic rd_en;    // read the store entry at the scan index
        logic cmp_en;   // compare the read entry, step the index
        logic finish;   // append if needed, load the result register
    } siu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic second;      // latched element belongs to list B
        logic count_zero;  // store is empty
        logic last_idx;    // scan index points at the last stored entry
        logic out_free;    // result register can take a new result
    } siu_status_t;

endpackage
`default_nettype wire

### rtl/siu_ifs.sv
`default_nettype none
interface siu_elem_if;
    logic                            valid;
    logic                            ready;
    logic                            start_req;
    logic                            is_second;
    logic signed [siu_pkg::VALUE_W-1:0] value;

    modport source (output valid, output start_req, output is_second, output value,
                    input ready);
    modport sink   (input valid, input start_req, input is_second, input value,
                    output ready);
endinterface

interface siu_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [siu_pkg::VALUE_W-1:0] echo_value;
    logic [siu_pkg::MATCH_W-1:0]     match_count;
    logic                            added;
    logic                            overflow;

    modport source (output valid, output echo_value, output match_count, output added,
                    output overflow, input ready);
    modport sink   (input valid, input echo_value, input match_count, input added,
                    input overflow, output ready);
endinterface
`default_nettype wire

### rtl/siu_ctrl.sv
`default_nettype none
module siu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output siu_pkg::siu_cmd_t         cmd,
    input  wire siu_pkg::siu_status_t status
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_READ     = 3'd2;
    localparam logic [2:0] S_CMP      = 3'd3;
    localparam logic [2:0] S_FINISH   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!status.second || status.count_zero)
                    state_next = S_FINISH;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_en = 1'b1;
                state_next = status.last_idx ? S_FINISH : S_READ;
            end
            S_FINISH:
            begin
                // hold here while the previous result is still waiting
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### rtl/siu_dp.sv
`default_nettype none
module siu_dp #(
    parameter int STORE_DEPTH = siu_pkg::STORE_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire siu_pkg::siu_cmd_t                    cmd,
    output siu_pkg::siu_status_t                      status,
    input  wire logic                                 in_start_req,
    input  wire logic                                 in_is_second,
    input  wire logic signed [siu_pkg::VALUE_W-1:0]   in_value,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [siu_pkg::VALUE_W-1:0]        out_echo_value,
    output logic [siu_pkg::MATCH_W-1:0]               out_match_count,
    output logic                                      out_added,
    output logic                                      out_overflow
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int IW = $clog2(STORE_DEPTH);
    localparam int VW = siu_pkg::VALUE_W;
    localparam int MW = siu_pkg::MATCH_W;

    // entry word: {from list A, value}
    logic [VW:0]          mem [STORE_DEPTH];
    logic [VW:0]          rdata_reg;

    logic [CW-1:0]        count_reg;
    logic [IW-1:0]        idx_reg;
    logic                 second_reg;
    logic [VW-1:0]        value_reg;
    logic                 seen_reg;
    logic [MW-1:0]        match_reg;

    logic                 out_valid_reg;
    logic [VW-1:0]        out_value_reg;
    logic [MW-1:0]        out_match_reg;
    logic                 out_added_reg;
    logic                 out_overflow_reg;

    logic                 want_add;
    logic                 full;
    logic                 hit;
    logic [CW-1:0]        count_m1;

    assign want_add = !second_reg || !seen_reg;
    assign full     = (count_reg == CW'(STORE_DEPTH));
    assign hit      = (rdata_reg[VW-1:0] == value_reg);
    assign count_m1 = count_reg - 1'b1;

    assign status.second     = second_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.last_idx   = (idx_reg == count_m1[IW-1:0]);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rdata_reg <= mem[idx_reg];
        if (cmd.finish && want_add && !full)
            mem[count_reg[IW-1:0]] <= {!second_reg, value_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            second_reg <= in_is_second;
            value_reg  <= in_value;
            idx_reg    <= '0;
            seen_reg   <= 1'b0;
            match_reg  <= '0;
        end
        else if (cmd.cmp_en)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (hit)
            begin
                seen_reg <= 1'b1;
                if (rdata_reg[VW] && match_reg != siu_pkg::MATCH_MAX)
                    match_reg <= match_reg + 1'b1;
            end
        end
        if (cmd.finish)
        begin
            out_value_reg    <= value_reg;
            out_match_reg    <= second_reg ? match_reg : '0;
            out_added_reg    <= want_add && !full;
            out_overflow_reg <= want_add && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_start_req)
                count_reg <= '0;
            else if (cmd.finish && want_add && !full)
                count_reg <= count_reg + 1'b1;

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_echo_value  = out_value_reg;
    assign out_match_count = out_match_reg;
    assign out_added       = out_added_reg;
    assign out_overflow    = out_overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("entry count beyond store depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_added_reg && out_overflow_reg))
        else $error("added and overflow both set");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && want_add && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not advance the entry count");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp_en |-> count_reg != '0)
        else $error("scan of an empty store");

endmodule
`default_nettype wire

### rtl/set_intersect_union_unit.sv
`default_nettype none
// Streaming set intersection and union. Send the list A elements, then the
// list B elements, one transfer each; start_req on the first element of a new
// pair clears the store. Every element yields one result transfer. An A
// element is appended to the store (duplicates kept). A B element is scanned
// against all stored entries; match_count counts equal list-A entries, and
// the element is appended if it equals no stored entry. A full store sets
// overflow and drops the element. An A element, or a B element on an empty
// store, goes through dispatch and finish to the result register; a B
// element on a non-empty store first scans one entry per read-compare step
// of the single-port store with a registered read. Finish waits for a free
// output register; the next element is taken once the result is loaded.
module set_intersect_union_unit #(
    parameter int STORE_DEPTH = siu_pkg::STORE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    siu_elem_if.sink     elem,
    siu_result_if.source result
);

    siu_pkg::siu_cmd_t    cmd;
    siu_pkg::siu_status_t status;
    logic                 ctrl_ready;

    siu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (elem.valid),
        .in_ready (ctrl_ready),
        .cmd      (cmd),
        .status   (status)
    );

    siu_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_start_req    (elem.start_req),
        .in_is_second    (elem.is_second),
        .in_value        (elem.value),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_echo_value  (result.echo_value),
        .out_match_count (result.match_count),
        .out_added       (result.added),
        .out_overflow    (result.overflow)
    );

    assign elem.ready = ctrl_ready;

endmodule
`default_nettype wire
